[rtl/histogram_equalizer_macros.svh]
// ---------------------------------------------------------------------------
// Histogram equalizer assertion macros
// Shared concurrent assertion wrappers for the equalizer checkers.
// ---------------------------------------------------------------------------
`ifndef HISTOGRAM_EQUALIZER_MACROS_SVH
`define HISTOGRAM_EQUALIZER_MACROS_SVH

// Check on every clock edge outside reset
`define HEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every clock edge, reset included
`define HEQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/heq_pkg.sv]
// ---------------------------------------------------------------------------
// Histogram equalizer package
// Fixed widths, Q1.16 constants, action and register codes, FSM states.
// ---------------------------------------------------------------------------
package heq_pkg;

  localparam int unsigned PIX_W     = 16;
  localparam int unsigned Q_W       = 17;
  localparam int unsigned FRAC_W    = 16;
  localparam logic [16:0] ONE_Q     = 17'h10000;
  localparam int unsigned DIV_STEPS = 17;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  typedef enum logic [1:0] {
    ACT_ACCUM = 2'd0,
    ACT_FINAL = 2'd1,
    ACT_MAP   = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic {
    REG_MIN = 1'b0,
    REG_MAX = 1'b1
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_IDLE,
    ST_NORM,
    ST_NWAIT,
    ST_BIN,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_MAP_RD,
    ST_MAP_MUL,
    ST_MAP_SUM,
    ST_MAP_SCL,
    ST_MAP_OUT,
    ST_FIN_RD,
    ST_FIN_DIV,
    ST_FIN_WAIT,
    ST_FIN_END,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [PIX_W-1:0] min_val;
    logic signed [PIX_W-1:0] max_val;
  } cfg_t;

endpackage

[rtl/heq_stream_if.sv]
// ---------------------------------------------------------------------------
// Histogram equalizer stream interfaces
// Valid/ready channels for pixel items in and equalized results out.
// ---------------------------------------------------------------------------
interface heq_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       action;
  logic signed [heq_pkg::PIX_W-1:0] pixel_in;
  logic                             defined;
  logic                             last_pixel;

  modport source (output valid, action, pixel_in, defined, last_pixel, input ready);
  modport sink   (input valid, action, pixel_in, defined, last_pixel, output ready);
endinterface

interface heq_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [heq_pkg::PIX_W-1:0] pixel_out;
  logic                             out_defined;
  logic                             table_ready;
  logic                             out_last;

  modport source (output valid, pixel_out, out_defined, table_ready, out_last, input ready);
  modport sink   (input valid, pixel_out, out_defined, table_ready, out_last, output ready);
endinterface

[rtl/heq_cfg.sv]
// ---------------------------------------------------------------------------
// Histogram equalizer register file
// APB-style access to the minimum and maximum range registers.
// ---------------------------------------------------------------------------
module heq_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [heq_pkg::APB_AW-1:0]    paddr,
  input  logic [heq_pkg::APB_DW-1:0]    pwdata,
  output logic [heq_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  output heq_pkg::cfg_t                 cfg_o
);

  heq_pkg::reg_idx_e idx;
  logic              wr_en;
  heq_pkg::cfg_t     cfg_q;

  assign idx    = heq_pkg::reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Write the addressed register on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_val <= 16'sd0;
      cfg_q.max_val <= 16'sd32767;
    end else if (wr_en) begin
      case (idx)
        heq_pkg::REG_MIN: cfg_q.min_val <= pwdata[heq_pkg::PIX_W-1:0];
        heq_pkg::REG_MAX: cfg_q.max_val <= pwdata[heq_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the sign-extended register value
  always_comb begin
    case (idx)
      heq_pkg::REG_MIN: prdata = heq_pkg::APB_DW'(cfg_q.min_val);
      heq_pkg::REG_MAX: prdata = heq_pkg::APB_DW'(cfg_q.max_val);
      default:          prdata = '0;
    endcase
  end

endmodule

[rtl/heq_div.sv]
// ---------------------------------------------------------------------------
// Histogram equalizer divider
// Restoring divider, one quotient bit per cycle, result capped at 1.0 Q1.16.
// ---------------------------------------------------------------------------
module heq_div #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [NUM_W-1:0]          num_i,
  input  logic [DEN_W-1:0]          den_i,
  output logic                      done_o,
  output logic [heq_pkg::Q_W-1:0]   quo_o
);

  localparam int unsigned QW    = heq_pkg::Q_W;
  localparam int unsigned CMP_W = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;
  localparam int unsigned CNT_W = $clog2(heq_pkg::DIV_STEPS + 1);

  logic [CMP_W-1:0] num_ext;
  logic [CMP_W-1:0] den_top;
  logic             ovf;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             ge;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [QW-1:0]    quo_q;

  assign num_ext   = CMP_W'(num_i);
  assign den_top   = CMP_W'({den_i, {QW{1'b0}}});
  assign ovf       = num_ext >= den_top;
  assign trial     = {rem_q, quo_q[QW-1]};
  assign ge        = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};

  // Sequence the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= !ovf;
        done_q <= ovf;
        cnt_q  <= CNT_W'(heq_pkg::DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift dividend bits in, quotient bits out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= num_ext[DEN_W+QW-1:QW];
      quo_q <= ovf ? heq_pkg::ONE_Q : num_i[QW-1:0];
    end else if (busy_q) begin
      rem_q <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = (quo_q > heq_pkg::ONE_Q) ? heq_pkg::ONE_Q : quo_q;

endmodule

[rtl/histogram_equalizer.sv]
// Accumulate and map items pass through the normalization divider, except when the pixel
// normalizes to zero; undefined pixels go straight to the result. Finalize reads each bin,
// starts the divider and waits for its quotient (no divider when no pixels were accumulated),
// then writes the top table entry; clear zeroes each histogram bin in turn.
// Throughput: one item in flight; the next transfer is taken once the result is queued.
// Reset: control clears at once, then a pass zeroes both memories.
// ---------------------------------------------------------------------------
// Histogram equalizer top level
// Memory-based histogram, cumulative table build and interpolating map.
// ---------------------------------------------------------------------------
module histogram_equalizer #(
  parameter int unsigned BINS       = 100,
  parameter int unsigned COUNT_BITS = 21
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [heq_pkg::APB_AW-1:0]  paddr,
  input  logic [heq_pkg::APB_DW-1:0]  pwdata,
  output logic [heq_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  heq_in_if.sink                      pix_in,
  heq_out_if.source                   pix_out
);

  localparam int unsigned PW       = heq_pkg::PIX_W;
  localparam int unsigned QW       = heq_pkg::Q_W;
  localparam int unsigned FW       = heq_pkg::FRAC_W;
  localparam int unsigned BIN_AW   = $clog2(BINS);
  localparam int unsigned TAB_AW   = $clog2(BINS + 1);
  localparam int unsigned ACC_W    = COUNT_BITS + $clog2(BINS);
  localparam int unsigned NUM_W    = (ACC_W + FW > 32) ? ACC_W + FW : 32;
  localparam int unsigned DEN_W    = (COUNT_BITS > PW) ? COUNT_BITS : PW;
  localparam int unsigned SC_W     = QW + $clog2(BINS + 1);
  localparam int unsigned BH_W     = SC_W - FW;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration registers
  heq_pkg::cfg_t cfg;

  heq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  heq_pkg::state_e state_q, state_d;

  logic                  in_acc;
  heq_pkg::action_e      in_act;
  heq_pkg::action_e      act_q;
  logic signed [PW-1:0]  pix_q;
  logic                  def_q;
  logic                  last_q;

  logic [TAB_AW-1:0]     clr_q;
  logic                  clr_all_q;
  logic                  clr_end;
  logic [COUNT_BITS-1:0] total_q;
  logic                  ready_q;

  logic [QW-1:0]         n_q;
  logic [BIN_AW-1:0]     bin_q;
  logic [QW-1:0]         frac_q;
  logic [BIN_AW-1:0]     m_q;
  logic [ACC_W-1:0]      accu_q;
  logic [2*QW-1:0]       p0_q;
  logic [2*QW-1:0]       p1_q;
  logic [QW-1:0]         v_q;
  logic signed [2*QW:0]  prod_q;
  logic signed [PW-1:0]  res_q;
  logic                  res_def_q;

  logic                  out_valid_q;
  logic signed [PW-1:0]  out_pix_q;
  logic                  out_def_q;
  logic                  out_rdy_q;
  logic                  out_last_q;
  logic                  out_load;

  // Memories and their ports
  logic [COUNT_BITS-1:0] bin_mem [BINS];
  logic [QW-1:0]         tab_mem [BINS+1];
  logic                  bin_we;
  logic [BIN_AW-1:0]     bin_wa;
  logic [BIN_AW-1:0]     bin_ra;
  logic [COUNT_BITS-1:0] bin_wd;
  logic [COUNT_BITS-1:0] bin_rd_q;
  logic                  tab_we;
  logic [TAB_AW-1:0]     tab_wa;
  logic [QW-1:0]         tab_wd;
  logic [TAB_AW-1:0]     tab_ra0;
  logic [TAB_AW-1:0]     tab_ra1;
  logic [QW-1:0]         tab_rd0_q;
  logic [QW-1:0]         tab_rd1_q;

  // Divider
  logic                  div_start;
  logic [NUM_W-1:0]      div_num;
  logic [DEN_W-1:0]      div_den;
  logic                  div_done;
  logic [QW-1:0]         div_quo;
  logic                  fin_wr;

  // Normalization operands
  logic signed [PW:0]    diff;
  logic signed [PW:0]    span;
  logic signed [PW:0]    span_neg;
  logic signed [PW:0]    diff_adj;
  logic [PW-1:0]         span_abs;
  logic                  norm_pos;

  // Binning
  logic [SC_W-1:0]       scaled;
  logic [BH_W-1:0]       bin_hi;
  logic [BIN_AW-1:0]     bin_sel;
  logic [SC_W-1:0]       frac_full;

  // Map arithmetic
  logic [2*QW:0]         wsum;
  logic signed [QW:0]    v_s;
  logic signed [2*QW:0]  prod_d;
  logic signed [PW+2:0]  res_w;
  logic signed [PW-1:0]  res_sat;

  assign in_acc = pix_in.valid && pix_in.ready;
  assign in_act = heq_pkg::action_e'(pix_in.action);

  heq_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Normalize: fold the sign of the span into the numerator
  assign diff     = (PW+1)'(pix_q) - (PW+1)'(cfg.min_val);
  assign span     = (PW+1)'(cfg.max_val) - (PW+1)'(cfg.min_val);
  assign span_neg = -span;
  assign diff_adj = span[PW] ? -diff : diff;
  assign norm_pos = !diff_adj[PW] && (diff_adj != '0);

  always_comb begin
    if (span[PW]) begin
      span_abs = span_neg[PW-1:0];
    end else if (span == '0) begin
      span_abs = PW'(1);
    end else begin
      span_abs = span[PW-1:0];
    end
  end

  assign div_num = (state_q == heq_pkg::ST_FIN_DIV) ? NUM_W'({accu_q, {FW{1'b0}}})
                                                    : NUM_W'({diff_adj[PW-1:0], {FW{1'b0}}});
  assign div_den = (state_q == heq_pkg::ST_FIN_DIV) ? DEN_W'(total_q) : DEN_W'(span_abs);

  // Bin index and fraction, clamped to the top bin
  assign scaled    = SC_W'(n_q) * SC_W'(BINS);
  assign bin_hi    = scaled[SC_W-1:FW];
  assign bin_sel   = (bin_hi > BH_W'(BINS - 1)) ? BIN_AW'(BINS - 1) : bin_hi[BIN_AW-1:0];
  assign frac_full = scaled - (SC_W'(bin_sel) << FW);

  // Interpolate and rescale
  assign wsum   = (2*QW+1)'(p0_q) + (2*QW+1)'(p1_q);
  assign v_s    = {1'b0, v_q};
  assign prod_d = span * v_s;
  assign res_w  = (PW+3)'(cfg.min_val) + (PW+3)'(prod_q[2*QW:FW]);

  always_comb begin
    if (res_w > (PW+3)'(32767)) begin
      res_sat = 16'sh7fff;
    end else if (res_w < -(PW+3)'(32768)) begin
      res_sat = 16'sh8000;
    end else begin
      res_sat = res_w[PW-1:0];
    end
  end

  assign clr_end = (clr_q == (clr_all_q ? TAB_AW'(BINS) : TAB_AW'(BINS - 1)));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      heq_pkg::ST_CLR: begin
        if (clr_end) state_d = clr_all_q ? heq_pkg::ST_IDLE : heq_pkg::ST_DONE;
      end
      heq_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_act)
            heq_pkg::ACT_ACCUM: state_d = pix_in.defined ? heq_pkg::ST_NORM : heq_pkg::ST_DONE;
            heq_pkg::ACT_MAP:   state_d = pix_in.defined ? heq_pkg::ST_NORM : heq_pkg::ST_DONE;
            heq_pkg::ACT_FINAL: state_d = heq_pkg::ST_FIN_RD;
            heq_pkg::ACT_CLEAR: state_d = heq_pkg::ST_CLR;
            default:            state_d = heq_pkg::ST_DONE;
          endcase
        end
      end
      heq_pkg::ST_NORM:    state_d = norm_pos ? heq_pkg::ST_NWAIT : heq_pkg::ST_BIN;
      heq_pkg::ST_NWAIT: begin
        if (div_done) state_d = heq_pkg::ST_BIN;
      end
      heq_pkg::ST_BIN: begin
        state_d = (act_q == heq_pkg::ACT_ACCUM) ? heq_pkg::ST_ACC_RD : heq_pkg::ST_MAP_RD;
      end
      heq_pkg::ST_ACC_RD:  state_d = heq_pkg::ST_ACC_WR;
      heq_pkg::ST_ACC_WR:  state_d = heq_pkg::ST_DONE;
      heq_pkg::ST_MAP_RD:  state_d = heq_pkg::ST_MAP_MUL;
      heq_pkg::ST_MAP_MUL: state_d = heq_pkg::ST_MAP_SUM;
      heq_pkg::ST_MAP_SUM: state_d = heq_pkg::ST_MAP_SCL;
      heq_pkg::ST_MAP_SCL: state_d = heq_pkg::ST_MAP_OUT;
      heq_pkg::ST_MAP_OUT: state_d = heq_pkg::ST_DONE;
      heq_pkg::ST_FIN_RD:  state_d = heq_pkg::ST_FIN_DIV;
      heq_pkg::ST_FIN_DIV: state_d = heq_pkg::ST_FIN_WAIT;
      heq_pkg::ST_FIN_WAIT: begin
        if (fin_wr) begin
          state_d = (m_q == BIN_AW'(BINS - 1)) ? heq_pkg::ST_FIN_END : heq_pkg::ST_FIN_RD;
        end
      end
      heq_pkg::ST_FIN_END: state_d = heq_pkg::ST_DONE;
      heq_pkg::ST_DONE: begin
        if (!out_valid_q || pix_out.ready) state_d = heq_pkg::ST_IDLE;
      end
      default: state_d = heq_pkg::ST_IDLE;
    endcase
  end

  // Control outputs per state
  always_comb begin
    pix_in.ready = 1'b0;
    bin_we       = 1'b0;
    bin_wa       = bin_q;
    bin_wd       = '0;
    bin_ra       = bin_q;
    tab_we       = 1'b0;
    tab_wa       = TAB_AW'(m_q);
    tab_wd       = '0;
    div_start    = 1'b0;
    fin_wr       = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      heq_pkg::ST_CLR: begin
        bin_we = clr_q < TAB_AW'(BINS);
        bin_wa = clr_q[BIN_AW-1:0];
        tab_we = clr_all_q;
        tab_wa = clr_q;
      end
      heq_pkg::ST_IDLE:  pix_in.ready = 1'b1;
      heq_pkg::ST_NORM:  div_start = norm_pos;
      heq_pkg::ST_ACC_WR: begin
        bin_we = 1'b1;
        bin_wd = (bin_rd_q != COUNT_MAX) ? bin_rd_q + COUNT_BITS'(1) : bin_rd_q;
      end
      heq_pkg::ST_FIN_RD:  bin_ra = m_q;
      heq_pkg::ST_FIN_DIV: div_start = (total_q != '0);
      heq_pkg::ST_FIN_WAIT: begin
        fin_wr = (total_q == '0) || div_done;
        tab_we = fin_wr;
        tab_wd = (total_q == '0) ? '0 : div_quo;
      end
      heq_pkg::ST_FIN_END: begin
        tab_we = 1'b1;
        tab_wa = TAB_AW'(BINS);
        tab_wd = heq_pkg::ONE_Q;
      end
      heq_pkg::ST_DONE:  out_load = !out_valid_q || pix_out.ready;
      default: ;
    endcase
  end

  // Histogram count memory
  always_ff @(posedge clk_i) begin
    if (bin_we) bin_mem[bin_wa] <= bin_wd;
    bin_rd_q <= bin_mem[bin_ra];
  end

  // Cumulative table memory, two read ports for neighboring entries
  assign tab_ra0 = TAB_AW'(bin_q);
  assign tab_ra1 = TAB_AW'(bin_q) + TAB_AW'(1);

  always_ff @(posedge clk_i) begin
    if (tab_we) tab_mem[tab_wa] <= tab_wd;
    tab_rd0_q <= tab_mem[tab_ra0];
    tab_rd1_q <= tab_mem[tab_ra1];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= heq_pkg::ST_CLR;
      clr_q       <= '0;
      clr_all_q   <= 1'b1;
      total_q     <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == heq_pkg::ST_CLR) begin
        clr_q <= clr_end ? '0 : clr_q + TAB_AW'(1);
        if (clr_end) clr_all_q <= 1'b0;
      end
      if (in_acc && in_act == heq_pkg::ACT_CLEAR) begin
        total_q <= '0;
        ready_q <= 1'b0;
      end
      if (state_q == heq_pkg::ST_ACC_WR && total_q != COUNT_MAX) begin
        total_q <= total_q + COUNT_BITS'(1);
      end
      if (state_q == heq_pkg::ST_FIN_END) ready_q <= 1'b1;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pix_out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      heq_pkg::ST_IDLE: begin
        if (in_acc) begin
          act_q     <= in_act;
          pix_q     <= pix_in.pixel_in;
          def_q     <= pix_in.defined;
          last_q    <= pix_in.last_pixel;
          res_q     <= pix_in.pixel_in;
          res_def_q <= 1'b0;
          accu_q    <= '0;
          m_q       <= '0;
        end
      end
      heq_pkg::ST_NORM: begin
        if (!norm_pos) n_q <= '0;
      end
      heq_pkg::ST_NWAIT: begin
        if (div_done) n_q <= div_quo;
      end
      heq_pkg::ST_BIN: begin
        bin_q  <= bin_sel;
        frac_q <= frac_full[QW-1:0];
      end
      heq_pkg::ST_MAP_MUL: begin
        p0_q <= (2*QW)'(heq_pkg::ONE_Q - frac_q) * (2*QW)'(tab_rd0_q);
        p1_q <= (2*QW)'(frac_q) * (2*QW)'(tab_rd1_q);
      end
      heq_pkg::ST_MAP_SUM: v_q <= wsum[FW+QW-1:FW];
      heq_pkg::ST_MAP_SCL: prod_q <= prod_d;
      heq_pkg::ST_MAP_OUT: begin
        res_q     <= res_sat;
        res_def_q <= def_q;
      end
      heq_pkg::ST_FIN_DIV: accu_q <= accu_q + ACC_W'(bin_rd_q);
      heq_pkg::ST_FIN_WAIT: begin
        if (fin_wr) m_q <= m_q + BIN_AW'(1);
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q  <= res_q;
      out_def_q  <= res_def_q;
      out_rdy_q  <= ready_q;
      out_last_q <= last_q;
    end
  end

  assign pix_out.valid       = out_valid_q;
  assign pix_out.pixel_out   = out_pix_q;
  assign pix_out.out_defined = out_def_q;
  assign pix_out.table_ready = out_rdy_q;
  assign pix_out.out_last    = out_last_q;

endmodule

[rtl/heq_checker.sv]
// ---------------------------------------------------------------------------
// Histogram equalizer port checker
// Watches the top-level handshakes and the configuration port over time.
// ---------------------------------------------------------------------------
`include "histogram_equalizer_macros.svh"

module heq_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic pready_i
);

  // A stalled result stays offered
  `HEQ_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")

  // No input is taken back to back
  `HEQ_ASSERT(a_busy_after_transfer, in_valid_i && in_ready_i |=> !in_ready_i, "input taken twice in a row")

  // Configuration port never waits
  `HEQ_ASSERT_ALWAYS(a_pready_high, pready_i == 1'b1, "pready deasserted")

endmodule

bind histogram_equalizer heq_checker u_heq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_in.valid),
  .in_ready_i  (pix_in.ready),
  .out_valid_i (pix_out.valid),
  .out_ready_i (pix_out.ready),
  .pready_i    (pready)
);

[tb/histogram_equalizer_tb.sv]
// ---------------------------------------------------------------------------
// Histogram equalizer testbench
// Drives pixel items through accumulate, finalize, map and clear, predicts
// each equalized result using Q1.16 arithmetic and compares it field by field.
// ---------------------------------------------------------------------------
module histogram_equalizer_tb;

  localparam int unsigned NBINS    = 100;
  localparam int unsigned CNT_BITS = 21;
  localparam int unsigned CNT_MAX  = (1 << CNT_BITS) - 1;
  localparam longint      ONE      = 65536;
  localparam int unsigned IDLE_LIM = 20000;

  typedef struct packed {
    logic signed [15:0] pixel;
    logic               def;
    logic               ready;
    logic               last;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [heq_pkg::APB_AW-1:0] paddr = '0;
  logic [heq_pkg::APB_DW-1:0] pwdata = '0;
  logic [heq_pkg::APB_DW-1:0] prdata;
  logic pready;

  heq_in_if  pix_in ();
  heq_out_if pix_out ();

  histogram_equalizer #(.BINS(NBINS), .COUNT_BITS(CNT_BITS)) u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .pix_in (pix_in.sink),
    .pix_out(pix_out.source)
  );

  always #6 clk_i = ~clk_i;

  // Shadow state of the equalizer
  longint  eq_min, eq_max;
  longint  eq_counts [NBINS];
  longint  eq_cdf [NBINS+1];
  longint  eq_total;
  bit      eq_ready;
  result_t pending_px [$];

  int  errors = 0;
  int  idle_cycles = 0;
  bit  hold_off = 1'b0;
  bit  no_gaps = 1'b0;

  function automatic longint norm_q16(longint pix);
    longint span, num, q;
    span = eq_max - eq_min;
    num  = (pix - eq_min) * ONE;
    if (span == 0) span = 1;
    if (span < 0) begin
      span = -span;
      num  = -num;
    end
    if (num <= 0) return 0;
    q = num / span;
    return (q > ONE) ? ONE : q;
  endfunction

  // Advance the shadow state by one item and return its result
  function automatic result_t equalize(heq_pkg::action_e act, logic signed [15:0] pix,
                                       logic def, logic last);
    result_t r;
    longint n, scaled, b, frac, v, p, res, accu, e;
    r.pixel = pix;
    r.def   = 1'b0;
    r.last  = last;
    case (act)
      heq_pkg::ACT_ACCUM: begin
        if (def) begin
          scaled = norm_q16(pix) * NBINS;
          b = scaled >>> 16;
          if (b > NBINS - 1) b = NBINS - 1;
          if (eq_counts[b] < CNT_MAX) eq_counts[b]++;
          if (eq_total < CNT_MAX) eq_total++;
        end
      end
      heq_pkg::ACT_FINAL: begin
        accu = 0;
        for (int m = 0; m < NBINS; m++) begin
          e = 0;
          if (eq_total != 0) begin
            e = (accu << 16) / eq_total;
            if (e > ONE) e = ONE;
          end
          eq_cdf[m] = e;
          accu += eq_counts[m];
        end
        eq_cdf[NBINS] = ONE;
        eq_ready = 1'b1;
      end
      heq_pkg::ACT_MAP: begin
        if (def) begin
          n = norm_q16(pix);
          scaled = n * NBINS;
          b = scaled >>> 16;
          if (b > NBINS - 1) b = NBINS - 1;
          frac = scaled - (b << 16);
          v = ((ONE - frac) * eq_cdf[b] + frac * eq_cdf[b+1]) >>> 16;
          p = (eq_max - eq_min) * v;
          res = eq_min + ((p >= 0) ? p / ONE : -((-p + ONE - 1) / ONE));
          if (res > 32767) res = 32767;
          if (res < -32768) res = -32768;
          r.pixel = res[15:0];
          r.def = 1'b1;
        end
      end
      default: begin
        foreach (eq_counts[i]) eq_counts[i] = 0;
        eq_total = 0;
        eq_ready = 1'b0;
      end
    endcase
    r.ready = eq_ready;
    return r;
  endfunction

  // Write one register over the configuration port
  task automatic write_reg(heq_pkg::reg_idx_e idx, logic signed [15:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= heq_pkg::APB_AW'(4 * int'(idx));
    pwdata <= {{16{val[15]}}, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == heq_pkg::REG_MIN) eq_min = val;
    else eq_max = val;
  endtask

  // Offer one item until its transfer; valid drops only while idling
  task automatic send_pixel(heq_pkg::action_e act, logic signed [15:0] pix, logic def,
                            logic last);
    if (!no_gaps)
      while ($urandom_range(99) < 24) begin
        pix_in.valid <= 1'b0;
        @(posedge clk_i);
      end
    pix_in.valid <= 1'b1;
    pix_in.action <= act;
    pix_in.pixel_in <= pix;
    pix_in.defined <= def;
    pix_in.last_pixel <= last;
    do @(posedge clk_i); while (!pix_in.ready);
    pending_px = {pending_px, equalize(act, pix, def, last)};
  endtask

  task automatic drain();
    pix_in.valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_range(logic signed [15:0] lo, logic signed [15:0] hi);
    drain();
    write_reg(heq_pkg::REG_MIN, lo);
    write_reg(heq_pkg::REG_MAX, hi);
  endtask

  // Receiver with random stalls; hold_off forces a long stall
  always @(posedge clk_i) begin
    if (hold_off) pix_out.ready <= 1'b0;
    else pix_out.ready <= no_gaps || ($urandom_range(99) >= 24);
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      if (pending_px.size() == 0) begin
        $display("%0t: unexpected result pixel %0d", $time, pix_out.pixel_out);
        errors++;
      end else begin
        exp_r = pending_px.pop_front();
        if (pix_out.pixel_out !== exp_r.pixel) begin
          $display("%0t: pixel_out exp %0d got %0d", $time, exp_r.pixel, pix_out.pixel_out);
          errors++;
        end
        if (pix_out.out_defined !== exp_r.def) begin
          $display("%0t: out_defined exp %0b got %0b", $time, exp_r.def,
                   pix_out.out_defined);
          errors++;
        end
        if (pix_out.table_ready !== exp_r.ready) begin
          $display("%0t: table_ready exp %0b got %0b", $time, exp_r.ready,
                   pix_out.table_ready);
          errors++;
        end
        if (pix_out.out_last !== exp_r.last) begin
          $display("%0t: out_last exp %0b got %0b", $time, exp_r.last, pix_out.out_last);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk_i) begin
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) || psel)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIM) begin
      $display("status: fail");
      $finish;
    end
  end

  // One image pass: accumulate, finalize, map
  task automatic image_pass(int npix, int lo, int hi);
    for (int i = 0; i < npix; i++)
      send_pixel(heq_pkg::ACT_ACCUM, 16'($urandom_range(hi - lo) + lo),
                 $urandom_range(9) != 0, i == npix - 1);
    send_pixel(heq_pkg::ACT_FINAL, 16'($urandom), 1'($urandom), 1'b1);
    for (int i = 0; i < npix; i++)
      send_pixel(heq_pkg::ACT_MAP, 16'($urandom_range(hi - lo) + lo),
                 $urandom_range(9) != 0, i == npix - 1);
  endtask

  task automatic test_directed();
    send_pixel(heq_pkg::ACT_MAP, 16'sd1000, 1'b1, 1'b0);
    send_pixel(heq_pkg::ACT_ACCUM, -16'sd32768, 1'b1, 1'b0);
    send_pixel(heq_pkg::ACT_ACCUM, 16'sd32767, 1'b1, 1'b0);
    send_pixel(heq_pkg::ACT_ACCUM, 16'sd0, 1'b1, 1'b0);
    send_pixel(heq_pkg::ACT_ACCUM, 16'sd16383, 1'b0, 1'b1);
    send_pixel(heq_pkg::ACT_FINAL, 16'sd5, 1'b0, 1'b1);
    send_pixel(heq_pkg::ACT_MAP, 16'sd32767, 1'b1, 1'b0);
    send_pixel(heq_pkg::ACT_MAP, -16'sd32768, 1'b1, 1'b0);
    send_pixel(heq_pkg::ACT_MAP, 16'sd12345, 1'b0, 1'b1);
    send_pixel(heq_pkg::ACT_CLEAR, -16'sd1, 1'b1, 1'b1);
    send_pixel(heq_pkg::ACT_FINAL, 16'sd0, 1'b1, 1'b0);
    send_pixel(heq_pkg::ACT_MAP, 16'sd20000, 1'b1, 1'b1);
  endtask

  // Zero span, inverted span and full range
  task automatic test_ranges();
    set_range(16'sd100, 16'sd100);
    send_pixel(heq_pkg::ACT_ACCUM, 16'sd99, 1'b1, 1'b0);
    send_pixel(heq_pkg::ACT_ACCUM, 16'sd101, 1'b1, 1'b0);
    send_pixel(heq_pkg::ACT_FINAL, 16'sd0, 1'b0, 1'b0);
    send_pixel(heq_pkg::ACT_MAP, 16'sd101, 1'b1, 1'b1);
    set_range(16'sd32767, -16'sd32768);
    send_pixel(heq_pkg::ACT_CLEAR, 16'sd0, 1'b0, 1'b0);
    image_pass(12, -32768, 32767);
    set_range(-16'sd32768, 16'sd32767);
    image_pass(12, -32768, 32767);
  endtask

  task automatic test_backpressure();
    set_range(-16'sd1000, 16'sd1000);
    hold_off = 1'b1;
    fork
      begin
        for (int i = 0; i < 20; i++)
          send_pixel(heq_pkg::ACT_ACCUM, 16'($urandom_range(2000) - 1000), 1'b1, 1'b0);
      end
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    drain();
  endtask

  task automatic test_random();
    int lo, hi, n;
    for (int k = 0; k < 16; k++) begin
      lo = $urandom_range(65535) - 32768;
      hi = $urandom_range(65535) - 32768;
      set_range(16'(lo), 16'(hi));
      if (k == 5) no_gaps = 1'b1;
      if (k == 8) no_gaps = 1'b0;
      send_pixel(heq_pkg::ACT_CLEAR, 16'($urandom), 1'($urandom), 1'b0);
      n = $urandom_range(10, 40);
      if (lo < hi) image_pass(n, lo - (hi - lo) / 8 < -32768 ? -32768 : lo - (hi - lo) / 8,
                              hi);
      else image_pass(n, -32768, 32767);
      // Noise: accumulate, finalize or map, any field
      for (int i = 0; i < 6; i++)
        send_pixel(heq_pkg::action_e'($urandom_range(2)), 16'($urandom), 1'($urandom),
                   1'($urandom));
    end
  endtask

  initial begin
    pix_in.valid = 1'b0;
    pix_in.action = heq_pkg::ACT_ACCUM;
    pix_in.pixel_in = '0;
    pix_in.defined = 1'b0;
    pix_in.last_pixel = 1'b0;
    pix_out.ready = 1'b0;
    eq_min = 0;
    eq_max = 32767;
    eq_total = 0;
    eq_ready = 1'b0;
    foreach (eq_counts[i]) eq_counts[i] = 0;
    foreach (eq_cdf[i]) eq_cdf[i] = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_ranges();
    test_backpressure();
    test_random();
    drain();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending_px.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
